/* src/sdspi_pkg.sv */
`timescale 1ns / 1ps
package sdspi_pkg;

  localparam int unsigned BlockBytesDef = 512;
  localparam int unsigned NumCmds = 13;
  localparam logic [3:0] CmdRead = 4'd7;
  localparam logic [3:0] CmdWrite = 4'd8;

  typedef enum logic [1:0] {
    FUNC_CMD  = 2'd0,
    FUNC_READ = 2'd1,
    FUNC_WRITE = 2'd2,
    FUNC_BYTE = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    CFG_RESP_LIMIT = 3'd0,
    CFG_TOKEN_LIMIT = 3'd1,
    CFG_BUSY_LIMIT = 3'd2,
    CFG_HIGH_CAP = 3'd3,
    CFG_CARD_READY = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_OK = 3'd0,
    ST_NO_RESP = 3'd1,
    ST_NOT_READY = 3'd2,
    ST_TOKEN_TO = 3'd3,
    ST_WR_REJ = 3'd4,
    ST_BUSY_TO = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    PH_IDLE, PH_CMD, PH_POLL, PH_RESP, PH_BUSY, PH_TAIL, PH_DIS,
    PH_RDTOK, PH_RDDAT, PH_RDCRC, PH_WRTOK, PH_WRDAT, PH_WRCRC, PH_WRRESP, PH_WRBUSY
  } phase_e;

  // Classified item passed from the front part to the sequencer.
  typedef struct packed {
    func_e       func;
    logic        bad_sel;
    logic [3:0]  sel;
    logic [31:0] arg;
    logic [7:0]  miso;
    logic [7:0]  wr;
  } item_t;

  typedef struct packed {
    logic        send_valid;
    logic [7:0]  mosi_byte;
    logic        chip_select;
    logic        rd_valid;
    logic [7:0]  rd_byte;
    logic        wr_taken;
    logic        done_res;
    logic [2:0]  status;
    logic [39:0] resp_value;
  } result_t;

  function automatic logic [7:0] cmd_opcode(input logic [3:0] s);
    logic [5:0] n;
    case (s)
      4'd0: n = 6'd0;
      4'd1: n = 6'd1;
      4'd2: n = 6'd8;
      4'd3: n = 6'd9;
      4'd4: n = 6'd10;
      4'd5: n = 6'd13;
      4'd6: n = 6'd16;
      4'd7: n = 6'd17;
      4'd8: n = 6'd24;
      4'd9: n = 6'd55;
      4'd10: n = 6'd58;
      4'd11: n = 6'd41;
      4'd12: n = 6'd42;
      default: n = 6'd0;
    endcase
    return {2'b01, n};
  endfunction

  function automatic logic [2:0] cmd_resp_len(input logic [3:0] s);
    logic [2:0] l;
    case (s)
      4'd2, 4'd10: l = 3'd5;
      4'd5: l = 3'd2;
      default: l = 3'd1;
    endcase
    return l;
  endfunction

  function automatic logic cmd_release(input logic [3:0] s);
    logic r;
    case (s)
      4'd3, 4'd4, 4'd7, 4'd8: r = 1'b0;
      default: r = 1'b1;
    endcase
    return r;
  endfunction

endpackage

/* src/sdspi_front.sv */
`timescale 1ns / 1ps
module sdspi_front
  import sdspi_pkg::*;
#(
  parameter int unsigned BlockBytes = BlockBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [3:0]  cmd_sel_i,
  input  logic [31:0] arg_word_i,
  input  logic [7:0]  miso_byte_i,
  input  logic [7:0]  wr_byte_i,
  input  logic        high_cap_i,
  input  logic        card_ready_i,
  output logic        q_valid_o,
  input  logic        q_ready_i,
  output item_t       q_item_o
);

  localparam int unsigned Shift = $clog2(BlockBytes);

  // Two-entry queue between the front and the sequencer.
  item_t      mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  item_t      cls;
  logic       push, pop;

  // Classify the item: map block requests to their command and address.
  always_comb begin
    cls.func = func_e'(func_i);
    cls.sel = cmd_sel_i;
    cls.bad_sel = (cmd_sel_i >= 4'(NumCmds));
    cls.arg = arg_word_i;
    cls.miso = miso_byte_i;
    cls.wr = wr_byte_i;
    if (func_e'(func_i) == FUNC_READ || func_e'(func_i) == FUNC_WRITE) begin
      cls.sel = (func_e'(func_i) == FUNC_READ) ? CmdRead : CmdWrite;
      cls.bad_sel = !card_ready_i;
      if (!high_cap_i) begin
        cls.arg = arg_word_i << Shift;
      end
    end
  end

  assign in_ready_o = (cnt_q != 2'd2);
  assign push = in_valid_i && in_ready_o;
  assign pop = q_valid_o && q_ready_i;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_item_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 |-> !in_ready_o) else $error("queue overflow");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count out of range");
  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> cnt_q == $past(cnt_q) + 2'd1) else $error("queue count slip");
`endif

endmodule

/* src/sdspi_seq.sv */
`timescale 1ns / 1ps
module sdspi_seq
  import sdspi_pkg::*;
#(
  parameter int unsigned BlockBytes = BlockBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  output logic        q_ready_o,
  input  item_t       q_item_i,
  input  logic [7:0]  resp_limit_i,
  input  logic [7:0]  token_limit_i,
  input  logic [7:0]  busy_limit_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output result_t     out_res_o
);

  localparam int unsigned CntW = $clog2(BlockBytes + 1);

  phase_e      phase_q, phase_d;
  logic [CntW-1:0] bc_q, bc_d;
  logic [7:0]  pc_q, pc_d;
  logic [39:0] rs_q, rs_d;
  logic [3:0]  cc_q, cc_d;
  logic [31:0] arg_q, arg_d;
  logic [1:0]  kind_q, kind_d;
  logic [2:0]  pend_q, pend_d;
  result_t     r, out_q;
  logic        ov_q;
  logic        take;
  item_t       it;

  assign it = q_item_i;
  assign q_ready_o = !ov_q || out_ready_i;
  assign take = q_valid_i && q_ready_o;
  assign out_valid_o = ov_q;
  assign out_res_o = out_q;

  // Sequencer: one result per item, following the SPI byte stream.
  always_comb begin
    logic [CntW-1:0] bn;
    phase_d = phase_q; bc_d = bc_q; pc_d = pc_q; rs_d = rs_q; cc_d = cc_q;
    arg_d = arg_q; kind_d = kind_q; pend_d = pend_q;
    r = '0;
    bn = bc_q + 1'b1;
    if (it.func == FUNC_BYTE) begin
      case (phase_q)
        PH_CMD: begin
          bc_d = bn;
          if (bn <= CntW'(4)) begin
            r.send_valid = 1'b1; r.chip_select = 1'b1;
            case (bn[2:0])
              3'd1: r.mosi_byte = arg_q[31:24];
              3'd2: r.mosi_byte = arg_q[23:16];
              3'd3: r.mosi_byte = arg_q[15:8];
              default: r.mosi_byte = arg_q[7:0];
            endcase
          end else if (bn == CntW'(5)) begin
            r.send_valid = 1'b1; r.chip_select = 1'b1;
            r.mosi_byte = (cc_q == 4'd0) ? 8'h95 : ((cc_q == 4'd2) ? 8'h87 : 8'h01);
          end else if (resp_limit_i == 8'd0) begin
            pend_d = ST_NO_RESP; phase_d = PH_DIS; bc_d = '0;
            r.send_valid = 1'b1; r.chip_select = 1'b1; r.mosi_byte = 8'hff;
          end else begin
            phase_d = PH_POLL; pc_d = 8'd1;
            r.send_valid = 1'b1; r.chip_select = 1'b1; r.mosi_byte = 8'hff;
          end
        end
        PH_POLL, PH_RESP, PH_BUSY: begin
          logic go_after;
          go_after = 1'b0;
          if (phase_q == PH_POLL) begin
            if (!it.miso[7]) begin
              rs_d = {32'd0, it.miso};
              if (cmd_resp_len(cc_q) > 3'd1) begin
                phase_d = PH_RESP; bc_d = CntW'(1);
                r.send_valid = 1'b1; r.chip_select = 1'b1; r.mosi_byte = 8'hff;
              end else go_after = 1'b1;
            end else if (pc_q < resp_limit_i) begin
              pc_d = pc_q + 8'd1;
              r.send_valid = 1'b1; r.chip_select = 1'b1; r.mosi_byte = 8'hff;
            end else begin
              pend_d = ST_NO_RESP; phase_d = PH_DIS; bc_d = '0;
              r.send_valid = 1'b1; r.chip_select = 1'b1; r.mosi_byte = 8'hff;
            end
          end else if (phase_q == PH_RESP) begin
            rs_d = {rs_q[31:0], it.miso};
            bc_d = bn;
            if (bn < CntW'(cmd_resp_len(cc_q))) begin
              r.send_valid = 1'b1; r.chip_select = 1'b1; r.mosi_byte = 8'hff;
            end else go_after = 1'b1;
          end else begin
            go_after = 1'b1;
            if (it.miso == 8'd0 && pc_q < resp_limit_i) begin
              go_after = 1'b0;
              pc_d = pc_q + 8'd1;
              r.send_valid = 1'b1; r.chip_select = 1'b1; r.mosi_byte = 8'hff;
            end
          end
          // No listed command uses busy, so after the response comes release, a block data token, or the final result.
          if (go_after) begin
            r.send_valid = 1'b1; r.chip_select = 1'b1;
            if (cmd_release(cc_q)) begin
              phase_d = PH_TAIL; r.mosi_byte = 8'hff;
            end else if (kind_q == FUNC_READ) begin
              r.mosi_byte = 8'hff;
              if (token_limit_i == 8'd0) begin
                pend_d = ST_TOKEN_TO; phase_d = PH_DIS; bc_d = '0;
              end else begin
                phase_d = PH_RDTOK; pc_d = 8'd1;
              end
            end else if (kind_q == FUNC_WRITE) begin
              phase_d = PH_WRTOK; r.mosi_byte = 8'hfe;
            end else begin
              r.send_valid = 1'b0; r.chip_select = 1'b0;
              phase_d = PH_IDLE; r.done_res = 1'b1; r.status = ST_OK;
              r.resp_value = rs_d;
            end
          end
        end
        PH_TAIL: begin
          pend_d = ST_OK; phase_d = PH_DIS; bc_d = '0;
          r.send_valid = 1'b1; r.chip_select = 1'b1; r.mosi_byte = 8'hff;
        end
        PH_DIS: begin
          bc_d = bn;
          if (bn < CntW'(3)) begin
            r.send_valid = 1'b1; r.mosi_byte = 8'hff;
          end else begin
            phase_d = PH_IDLE; r.done_res = 1'b1; r.status = pend_q;
            r.resp_value = rs_q;
          end
        end
        PH_RDTOK: begin
          r.send_valid = 1'b1; r.chip_select = 1'b1; r.mosi_byte = 8'hff;
          if (it.miso == 8'hfe) begin
            phase_d = PH_RDDAT; bc_d = '0;
          end else if (pc_q < token_limit_i) begin
            pc_d = pc_q + 8'd1;
          end else begin
            pend_d = ST_TOKEN_TO; phase_d = PH_DIS; bc_d = '0;
          end
        end
        PH_RDDAT: begin
          r.rd_valid = 1'b1; r.rd_byte = it.miso;
          r.send_valid = 1'b1; r.chip_select = 1'b1; r.mosi_byte = 8'hff;
          bc_d = bn;
          if (bn >= CntW'(BlockBytes)) begin
            phase_d = PH_RDCRC; bc_d = '0;
          end
        end
        PH_RDCRC: begin
          bc_d = bn;
          r.send_valid = 1'b1; r.chip_select = 1'b1; r.mosi_byte = 8'hff;
          if (bn >= CntW'(2)) begin
            pend_d = ST_OK; phase_d = PH_DIS; bc_d = '0;
          end
        end
        PH_WRTOK: begin
          phase_d = PH_WRDAT; bc_d = '0;
          r.wr_taken = 1'b1;
          r.send_valid = 1'b1; r.chip_select = 1'b1; r.mosi_byte = it.wr;
        end
        PH_WRDAT: begin
          bc_d = bn;
          r.send_valid = 1'b1; r.chip_select = 1'b1;
          if (bn < CntW'(BlockBytes)) begin
            r.wr_taken = 1'b1; r.mosi_byte = it.wr;
          end else begin
            phase_d = PH_WRCRC; bc_d = '0; r.mosi_byte = 8'hff;
          end
        end
        PH_WRCRC: begin
          bc_d = bn;
          if (bn >= CntW'(2)) phase_d = PH_WRRESP;
          r.send_valid = 1'b1; r.chip_select = 1'b1; r.mosi_byte = 8'hff;
        end
        PH_WRRESP: begin
          r.send_valid = 1'b1; r.chip_select = 1'b1; r.mosi_byte = 8'hff;
          if (it.miso[4:0] != 5'h05) begin
            pend_d = ST_WR_REJ; phase_d = PH_DIS; bc_d = '0;
          end else if (busy_limit_i == 8'd0) begin
            pend_d = ST_BUSY_TO; phase_d = PH_DIS; bc_d = '0;
          end else begin
            phase_d = PH_WRBUSY; pc_d = 8'd1;
          end
        end
        PH_WRBUSY: begin
          r.send_valid = 1'b1; r.chip_select = 1'b1; r.mosi_byte = 8'hff;
          if (it.miso == 8'hff) begin
            pend_d = ST_OK; phase_d = PH_DIS; bc_d = '0;
          end else if (pc_q < busy_limit_i) begin
            pc_d = pc_q + 8'd1;
          end else begin
            pend_d = ST_BUSY_TO; phase_d = PH_DIS; bc_d = '0;
          end
        end
        default: phase_d = PH_IDLE;
      endcase
    end else if (phase_q == PH_IDLE) begin
      rs_d = '0;
      if (it.bad_sel) begin
        r.done_res = 1'b1;
        r.status = (it.func == FUNC_CMD) ? ST_NO_RESP : ST_NOT_READY;
      end else begin
        cc_d = it.sel; arg_d = it.arg; kind_d = it.func;
        phase_d = PH_CMD; bc_d = '0;
        r.send_valid = 1'b1; r.chip_select = 1'b1; r.mosi_byte = cmd_opcode(it.sel);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= r;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE; bc_q <= '0; pc_q <= '0; rs_q <= '0; cc_q <= '0;
      arg_q <= '0; kind_q <= '0; pend_q <= '0; ov_q <= 1'b0;
    end else begin
      if (take) begin
        phase_q <= phase_d; bc_q <= bc_d; pc_q <= pc_d; rs_q <= rs_d; cc_q <= cc_d;
        arg_q <= arg_d; kind_q <= kind_d; pend_q <= pend_d;
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && r.done_res |=> phase_q == PH_IDLE) else $error("done without idle");
  a_done_no_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && out_q.done_res |-> !out_q.send_valid) else $error("done with send");
  a_rd_in_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && r.rd_valid |-> phase_q == PH_RDDAT) else $error("stray read byte");
`endif

endmodule

/* src/sd_spi_command_block_transfer.sv */
`timescale 1ns / 1ps
// SD card host sequencer in SPI mode for one card.
// Input channel (in_valid_i/in_ready_o): a request (func 0 command, 1 block
// read, 2 block write) or a func 3 item that reports the byte just received.
// Output channel (out_valid_o/out_ready_i): one result per item, naming the
// next byte to exchange, a read data byte, or the final status.
// An item is written into the queue at the edge that accepts it, and the
// sequencer registers its result in the output register at the edge that
// takes the item from the queue. Throughput: one item per cycle while the
// receiver accepts results (out_ready_i high).
// Configuration is a plain write port (cfg_we_i, cfg_idx_i, cfg_data_i); the user must
// write it only while idle, as the block itself does not enforce this.
// Reset puts all limits to 100, clears high-capacity and card-ready, and
// returns the sequencer to idle with an empty queue.
// When the receiver stalls, the result waits in the output register, the
// two-entry queue fills, and then in_ready_o falls.
module sd_spi_command_block_transfer
  import sdspi_pkg::*;
#(
  parameter int unsigned BlockBytes = BlockBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [3:0]  cmd_sel_i,
  input  logic [31:0] arg_word_i,
  input  logic [7:0]  miso_byte_i,
  input  logic [7:0]  wr_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        send_valid_o,
  output logic [7:0]  mosi_byte_o,
  output logic        chip_select_o,
  output logic        rd_valid_o,
  output logic [7:0]  rd_byte_o,
  output logic        wr_taken_o,
  output logic        done_res_o,
  output logic [2:0]  status_o,
  output logic [39:0] resp_value_o
);

  logic [7:0] resp_lim_q, tok_lim_q, busy_lim_q;
  logic       hc_q, rdy_q;
  logic       q_valid, q_ready;
  item_t      q_item;
  result_t    res;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      resp_lim_q <= 8'd100; tok_lim_q <= 8'd100; busy_lim_q <= 8'd100;
      hc_q <= 1'b0; rdy_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_RESP_LIMIT: resp_lim_q <= cfg_data_i;
        CFG_TOKEN_LIMIT: tok_lim_q <= cfg_data_i;
        CFG_BUSY_LIMIT: busy_lim_q <= cfg_data_i;
        CFG_HIGH_CAP: hc_q <= cfg_data_i[0];
        CFG_CARD_READY: rdy_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  sdspi_front #(.BlockBytes(BlockBytes)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .func_i, .cmd_sel_i, .arg_word_i,
    .miso_byte_i, .wr_byte_i, .high_cap_i(hc_q), .card_ready_i(rdy_q),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_item_o(q_item)
  );

  sdspi_seq #(.BlockBytes(BlockBytes)) u_seq (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_ready_o(q_ready), .q_item_i(q_item),
    .resp_limit_i(resp_lim_q), .token_limit_i(tok_lim_q), .busy_limit_i(busy_lim_q),
    .out_valid_o, .out_ready_i, .out_res_o(res)
  );

  assign send_valid_o = res.send_valid;
  assign mosi_byte_o = res.mosi_byte;
  assign chip_select_o = res.chip_select;
  assign rd_valid_o = res.rd_valid;
  assign rd_byte_o = res.rd_byte;
  assign wr_taken_o = res.wr_taken;
  assign done_res_o = res.done_res;
  assign status_o = res.status;
  assign resp_value_o = res.resp_value;

endmodule
